>>> rtl/exg_pkg.sv
`default_nettype none

package exg_pkg;

  // Default channel width of the pixel fields.
  localparam int CHANNEL_BITS_DEF = 8;

  // Width of the excess-green result and of the quotient it comes from.
  localparam int OUT_BITS = 8;

  // Largest result value, used when the ratio exceeds one.
  localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

  // Positions of the color channels in the per-channel arrays.
  localparam int CH_B = 0;
  localparam int CH_G = 1;
  localparam int CH_R = 2;
  localparam int NUM_CH = 3;

  // Input command codes.
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_PEAK,
    S_MUL_PIX,
    S_SUM,
    S_DECIDE,
    S_DIV,
    S_DONE
  } exg_state_e;

endpackage

`default_nettype wire

>>> rtl/exg_peak.sv
`default_nettype none

module exg_peak #(
  parameter int CHANNEL_BITS = exg_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        upd_i,
  input  wire logic                                        clr_i,
  input  wire logic [exg_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] pix_i,
  output logic      [exg_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] peak_o
);

  logic [exg_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] peak_q;
  logic [exg_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] peak_d;
  logic [exg_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] base;

  // A frame start clears the running maxima before the pixel is folded in.
  always_comb begin
    for (int i = 0; i < exg_pkg::NUM_CH; i++) begin
      base[i]   = clr_i ? '0 : peak_q[i];
      peak_d[i] = (pix_i[i] > base[i]) ? pix_i[i] : base[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (upd_i) begin
      peak_q <= peak_d;
    end
  end

  assign peak_o = peak_q;

endmodule

`default_nettype wire

>>> rtl/exg_mul.sv
`default_nettype none

// Three bit-serial shift-add multipliers that run in lockstep. The multiplier
// operand is consumed one bit per cycle, most significant bit first.
module exg_mul #(
  parameter int CHANNEL_BITS = exg_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            start_i,
  input  wire logic [exg_pkg::NUM_CH-1:0][2*CHANNEL_BITS-1:0]  mcand_i,
  input  wire logic [exg_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]    mplier_i,
  output logic                                                 done_o,
  output logic      [exg_pkg::NUM_CH-1:0][3*CHANNEL_BITS-1:0]  prod_o
);

  localparam int MW = 2 * CHANNEL_BITS;
  localparam int PW = 3 * CHANNEL_BITS;
  localparam int CW = $clog2(CHANNEL_BITS);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;

  logic [exg_pkg::NUM_CH-1:0][MW-1:0]           mcand_q;
  logic [exg_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] mplier_q;
  logic [exg_pkg::NUM_CH-1:0][PW-1:0]           acc_q;
  logic [exg_pkg::NUM_CH-1:0][PW-1:0]           acc_d;

  // Bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(CHANNEL_BITS - 1);
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // One shift-add step per lane: double the partial product and add the
  // multiplicand when the current multiplier bit is set.
  always_comb begin
    for (int i = 0; i < exg_pkg::NUM_CH; i++) begin
      acc_d[i] = {acc_q[i][PW-2:0], 1'b0}
               + (mplier_q[i][CHANNEL_BITS-1] ? PW'(mcand_q[i]) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      mplier_q <= mplier_q << 1;
      acc_q    <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> rtl/exg_div.sv
`default_nettype none

// Restoring radix-2 divider for floor(255 * num / den) with num <= den, so
// the quotient fits in the result width. One quotient bit per cycle.
module exg_div #(
  parameter int CHANNEL_BITS = exg_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [3*CHANNEL_BITS+1:0]      num_i,
  input  wire logic [3*CHANNEL_BITS+1:0]      den_i,
  output logic                                done_o,
  output logic      [exg_pkg::OUT_BITS-1:0]   quo_o
);

  localparam int NW  = 3 * CHANNEL_BITS + 2;
  localparam int QB  = exg_pkg::OUT_BITS;
  localparam int RW  = NW + QB;
  localparam int QCW = $clog2(QB);

  logic           busy_q;
  logic           done_q;
  logic [QCW-1:0] cnt_q;
  logic [RW-1:0]  rem_q;
  logic [RW-1:0]  dsr_q;
  logic [QB-1:0]  quo_q;
  logic           ge;
  logic [RW-1:0]  scaled;

  // The dividend is 255 * num, formed as num * 256 - num.
  assign scaled = {num_i, {QB{1'b0}}} - RW'(num_i);
  assign ge     = (rem_q >= dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= QCW'(QB - 1);
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Compare and subtract against the divisor, which walks down one bit
  // position per cycle from den * 128.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= scaled;
      dsr_q <= RW'(den_i) << (QB - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[QB-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> rtl/excess_green_pixel_index_core.sv
// Measure word: leaves the sequencer idle, so the next word can be accepted in the cycle after.
// Convert word: the input stalls while two bit-serial multiply passes and an 8-step serial
// divider run and while a finished result waits on a stalled output; the next word is taken
// in the cycle in which the result is offered, so one convert word is in flight at a time.
// A zero peak skips both multiply passes and the divider; a non-positive or saturated value
// skips the divider. Reset clears peaks and control.
`default_nettype none

module excess_green_pixel_index_core #(
  parameter int CHANNEL_BITS = exg_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic                          frame_start_i,
  input  wire logic [CHANNEL_BITS-1:0]       blue_i,
  input  wire logic [CHANNEL_BITS-1:0]       green_i,
  input  wire logic [CHANNEL_BITS-1:0]       red_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [exg_pkg::OUT_BITS-1:0]  excess_green_o,
  output logic                               saturated_o
);

  localparam int C  = CHANNEL_BITS;
  localparam int MW = 2 * C;
  localparam int PW = 3 * C;
  localparam int NW = 3 * C + 2;
  localparam int NC = exg_pkg::NUM_CH;

  exg_pkg::exg_state_e state_q, state_d;

  logic                  accept;
  logic                  load_out;
  logic                  peak_zero;
  logic [NC-1:0][C-1:0]  pix_in;
  logic [NC-1:0][C-1:0]  pix_q;
  logic [NC-1:0][C-1:0]  peak;

  logic                  mul_start;
  logic                  mul_done;
  logic [NC-1:0][MW-1:0] mul_mcand;
  logic [NC-1:0][C-1:0]  mul_mplier;
  logic [NC-1:0][PW-1:0] mul_prod;

  logic                  div_start;
  logic                  div_done;
  logic [exg_pkg::OUT_BITS-1:0] div_quo;
  logic [NW-1:0]         div_num;

  logic [NW-1:0]         den_q;
  logic [NW-1:0]         neg_q;
  logic [NW-1:0]         tg_q;
  logic [NW:0]           pos2;
  logic [NW:0]           neg2;

  logic [exg_pkg::OUT_BITS-1:0] res_val_q, res_val_d;
  logic                         res_sat_q, res_sat_d;

  logic                         out_valid_q, out_valid_d;
  logic [exg_pkg::OUT_BITS-1:0] out_val_q;
  logic                         out_sat_q;

  assign pix_in[exg_pkg::CH_B] = blue_i;
  assign pix_in[exg_pkg::CH_G] = green_i;
  assign pix_in[exg_pkg::CH_R] = red_i;

  assign in_stall_o = (state_q != exg_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign peak_zero  = (peak[exg_pkg::CH_B] == '0) || (peak[exg_pkg::CH_G] == '0)
                   || (peak[exg_pkg::CH_R] == '0);

  // Running channel maxima.
  exg_peak #(
    .CHANNEL_BITS(C)
  ) u_peak (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (accept && (cmd_i == exg_pkg::CMD_MEASURE)),
    .clr_i  (frame_start_i),
    .pix_i  (pix_in),
    .peak_o (peak)
  );

  // The first pass forms the peak pair products G*R, B*R and B*G; the second
  // multiplies them by the pixel's own b, g and r.
  always_comb begin
    if (state_q == exg_pkg::S_IDLE) begin
      mul_mcand[exg_pkg::CH_B]  = MW'(peak[exg_pkg::CH_G]);
      mul_mcand[exg_pkg::CH_G]  = MW'(peak[exg_pkg::CH_B]);
      mul_mcand[exg_pkg::CH_R]  = MW'(peak[exg_pkg::CH_B]);
      mul_mplier[exg_pkg::CH_B] = peak[exg_pkg::CH_R];
      mul_mplier[exg_pkg::CH_G] = peak[exg_pkg::CH_R];
      mul_mplier[exg_pkg::CH_R] = peak[exg_pkg::CH_G];
    end else begin
      for (int i = 0; i < NC; i++) begin
        mul_mcand[i]  = mul_prod[i][MW-1:0];
        mul_mplier[i] = pix_q[i];
      end
    end
  end

  exg_mul #(
    .CHANNEL_BITS(C)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  // Positive part 2*tg against negative part tb + tr. The value saturates
  // exactly when tg exceeds 2 * (tb + tr).
  assign pos2    = {tg_q, 1'b0};
  assign neg2    = {neg_q, 1'b0};
  assign div_num = NW'(pos2 - {1'b0, neg_q});

  exg_div #(
    .CHANNEL_BITS(C)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer for one convert word.
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    res_val_d = res_val_q;
    res_sat_d = res_sat_q;
    case (state_q)
      exg_pkg::S_IDLE: begin
        if (accept && (cmd_i == exg_pkg::CMD_CONVERT)) begin
          if (peak_zero) begin
            res_val_d = '0;
            res_sat_d = 1'b0;
            state_d   = exg_pkg::S_DONE;
          end else begin
            mul_start = 1'b1;
            state_d   = exg_pkg::S_MUL_PEAK;
          end
        end
      end
      exg_pkg::S_MUL_PEAK: begin
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = exg_pkg::S_MUL_PIX;
        end
      end
      exg_pkg::S_MUL_PIX: begin
        if (mul_done) begin
          state_d = exg_pkg::S_SUM;
        end
      end
      exg_pkg::S_SUM: begin
        state_d = exg_pkg::S_DECIDE;
      end
      exg_pkg::S_DECIDE: begin
        if (pos2 <= {1'b0, neg_q}) begin
          res_val_d = '0;
          res_sat_d = 1'b0;
          state_d   = exg_pkg::S_DONE;
        end else if ({1'b0, tg_q} > neg2) begin
          res_val_d = exg_pkg::OUT_MAX;
          res_sat_d = 1'b1;
          state_d   = exg_pkg::S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = exg_pkg::S_DIV;
        end
      end
      exg_pkg::S_DIV: begin
        if (div_done) begin
          res_val_d = div_quo;
          res_sat_d = 1'b0;
          state_d   = exg_pkg::S_DONE;
        end
      end
      exg_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = exg_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = exg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= exg_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pixel capture, sum terms and pending result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_in;
    end
    if (state_q == exg_pkg::S_SUM) begin
      den_q <= NW'(mul_prod[exg_pkg::CH_B]) + NW'(mul_prod[exg_pkg::CH_G])
             + NW'(mul_prod[exg_pkg::CH_R]);
      neg_q <= NW'(mul_prod[exg_pkg::CH_B]) + NW'(mul_prod[exg_pkg::CH_R]);
      tg_q  <= NW'(mul_prod[exg_pkg::CH_G]);
    end
    res_val_q <= res_val_d;
    res_sat_q <= res_sat_d;
  end

  // Output register: holds a finished word while the consumer stalls.
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_val_q <= res_val_q;
      out_sat_q <= res_sat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign excess_green_o = out_val_q;
  assign saturated_o    = out_sat_q;

endmodule

`default_nettype wire

>>> rtl/exg_check.sv
`default_nettype none

module exg_check #(
  parameter int CHANNEL_BITS = exg_pkg::CHANNEL_BITS_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         cmd_i,
  input wire logic                         frame_start_i,
  input wire logic [CHANNEL_BITS-1:0]      blue_i,
  input wire logic [CHANNEL_BITS-1:0]      green_i,
  input wire logic [CHANNEL_BITS-1:0]      red_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [exg_pkg::OUT_BITS-1:0] excess_green_o,
  input wire logic                         saturated_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i
      && $stable({cmd_i, frame_start_i, blue_i, green_i, red_i}))
    else $error("input word changed while stalled");

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A saturated result always carries the largest value.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> excess_green_o == exg_pkg::OUT_MAX)
    else $error("saturated flag without full-scale value");

  // A convert word keeps the input busy in the following cycle.
  a_convert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == exg_pkg::CMD_CONVERT) |=> in_stall_o)
    else $error("input taken again right after a convert word");

  // A measure word leaves the input free in the following cycle.
  a_measure_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == exg_pkg::CMD_MEASURE) |=> !in_stall_o)
    else $error("input stalled after a measure word");

endmodule

bind excess_green_pixel_index_core exg_check #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_exg_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .cmd_i          (cmd_i),
  .frame_start_i  (frame_start_i),
  .blue_i         (blue_i),
  .green_i        (green_i),
  .red_i          (red_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .excess_green_o (excess_green_o),
  .saturated_o    (saturated_o)
);

`default_nettype wire

>>> tb/tb_excess_green_pixel_index_core.sv
module tb_excess_green_pixel_index_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB           = exg_pkg::CHANNEL_BITS_DEF;
  localparam int OB           = exg_pkg::OUT_BITS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 430;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [OB-1:0] value;
    logic          sat;
  } exg_result_t;

  // Stimulus and response signals of the block.
  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          in_valid_i    = 1'b0;
  logic          cmd_i         = exg_pkg::CMD_MEASURE;
  logic          frame_start_i = 1'b0;
  logic [CB-1:0] blue_i        = '0;
  logic [CB-1:0] green_i       = '0;
  logic [CB-1:0] red_i         = '0;
  logic          out_stall_i   = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  logic [OB-1:0] excess_green_o;
  logic          saturated_o;

  // Running channel maxima as the block should hold them.
  logic [CB-1:0] max_blue  = '0;
  logic [CB-1:0] max_green = '0;
  logic [CB-1:0] max_red   = '0;

  exg_result_t expected_exg[$];

  int  mismatches     = 0;
  int  measure_words  = 0;
  int  convert_words  = 0;
  int  saturated_seen = 0;
  int  zero_seen      = 0;
  int  results_seen   = 0;
  int  cycle_count    = 0;
  bit  steady         = 1'b0;

  excess_green_pixel_index_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .frame_start_i  (frame_start_i),
    .blue_i         (blue_i),
    .green_i        (green_i),
    .red_i          (red_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .excess_green_o (excess_green_o),
    .saturated_o    (saturated_o)
  );

  // Free-running clock.
  always #2 clk_i = ~clk_i;

  // Exact excess-green ratio of one pixel against the current maxima.
  function automatic exg_result_t exg_ratio(input logic [CB-1:0] b, g, r);
    longint unsigned prod_b, prod_g, prod_r, num, den, pos, neg;
    exg_result_t res;
    res.value = '0;
    res.sat   = 1'b0;
    if (max_blue == 0 || max_green == 0 || max_red == 0) return res;
    prod_b = 64'(b) * 64'(max_green) * 64'(max_red);
    prod_g = 64'(g) * 64'(max_blue) * 64'(max_red);
    prod_r = 64'(r) * 64'(max_blue) * 64'(max_green);
    den = prod_b + prod_g + prod_r;
    if (den == 0) return res;
    pos = 2 * prod_g;
    neg = prod_b + prod_r;
    if (pos <= neg) return res;
    num = pos - neg;
    if (num > den) begin
      res.value = exg_pkg::OUT_MAX;
      res.sat   = 1'b1;
      return res;
    end
    res.value = OB'((64'(exg_pkg::OUT_MAX) * num) / den);
    return res;
  endfunction

  // Track an accepted word: measure words move the maxima, convert words
  // queue their expected result.
  function automatic void record_word(input logic cmd, fs, input logic [CB-1:0] b, g, r);
    exg_result_t res;
    if (cmd == exg_pkg::CMD_MEASURE) begin
      if (fs) begin
        max_blue  = '0;
        max_green = '0;
        max_red   = '0;
      end
      if (b > max_blue) max_blue = b;
      if (g > max_green) max_green = g;
      if (r > max_red) max_red = r;
      measure_words++;
    end else begin
      res = exg_ratio(b, g, r);
      expected_exg.push_back(res);
      convert_words++;
      if (res.sat) saturated_seen++;
      if (res.value == 0) zero_seen++;
    end
  endfunction

  // Channel value biased toward the extremes and small values.
  function automatic logic [CB-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CB'($urandom_range(0, 15));
      default: return CB'($urandom);
    endcase
  endfunction

  // Present one word after an optional random gap and wait until it is taken.
  task automatic send_word(input logic cmd, fs, input logic [CB-1:0] b, g, r);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 32) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    frame_start_i <= fs;
    blue_i        <= b;
    green_i       <= g;
    red_i         <= r;
    do @(posedge clk_i); while (in_stall_o);
    record_word(cmd, fs, b, g, r);
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_exg.size() != 0);
  endtask

  // Convert words see a zero maximum: before any measure pass and after frames with an empty channel.
  task automatic test_zero_peaks();
    send_word(exg_pkg::CMD_CONVERT, 1'b0, '1, '1, '1);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd0, 8'd200, 8'd0);
    send_word(exg_pkg::CMD_MEASURE, 1'b1, 8'd0, 8'd200, 8'd100);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd10, 8'd200, 8'd10);
    send_word(exg_pkg::CMD_MEASURE, 1'b1, 8'd255, 8'd0, 8'd255);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd0, 8'd255, 8'd0);
  endtask

  // Corners of the ratio: empty pixel, clipping, saturation, exact one.
  task automatic test_directed_corners();
    send_word(exg_pkg::CMD_MEASURE, 1'b1, '1, '1, '1);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd0, 8'd0, 8'd0);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd0, 8'd255, 8'd0);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd255, 8'd0, 8'd255);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd100, 8'd100, 8'd100);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd1, 8'd4, 8'd1);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd1, 8'd3, 8'd1);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd255, 8'd255, 8'd0);
    // A frame start on a convert word must leave the maxima alone.
    send_word(exg_pkg::CMD_CONVERT, 1'b1, 8'd0, 8'd255, 8'd0);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd1, 8'd3, 8'd1);
    send_word(exg_pkg::CMD_MEASURE, 1'b0, 8'd10, 8'd20, 8'd30);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd1, 8'd3, 8'd1);
    // Pixels above the maxima of a fresh frame.
    send_word(exg_pkg::CMD_MEASURE, 1'b1, 8'd10, 8'd20, 8'd30);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, '1, '1, '1);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd10, 8'd20, 8'd30);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd5, 8'd20, 8'd5);
    send_word(exg_pkg::CMD_MEASURE, 1'b1, 8'd1, 8'd1, 8'd1);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd0, 8'd1, 8'd0);
    send_word(exg_pkg::CMD_CONVERT, 1'b0, 8'd0, 8'd255, 8'd1);
  endtask

  // Let the pipeline empty completely in the middle of a frame.
  task automatic test_drain_pause();
    send_word(exg_pkg::CMD_MEASURE, 1'b1, 8'd200, 8'd220, 8'd180);
    repeat (4) send_word(exg_pkg::CMD_CONVERT, 1'b0, rand_chan(), rand_chan(), rand_chan());
    hold_until_drained();
    repeat (2) send_word(exg_pkg::CMD_CONVERT, 1'b0, rand_chan(), rand_chan(), rand_chan());
  endtask

  // Random frames: a measure pass opened by a frame start, then a convert
  // pass, with stray words mixed in.
  task automatic test_random_frames();
    int sent;
    int n_meas;
    int n_conv;
    int kind;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      steady = (sent >= 150 && sent < 250);
      n_meas = $urandom_range(1, 12);
      for (int i = 0; i < n_meas; i++) begin
        send_word(exg_pkg::CMD_MEASURE, i == 0, rand_chan(), rand_chan(), rand_chan());
        sent++;
      end
      n_conv = $urandom_range(1, 16);
      for (int i = 0; i < n_conv; i++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          send_word(exg_pkg::CMD_MEASURE, 1'($urandom_range(0, 1)), rand_chan(),
                    rand_chan(), rand_chan());
        end else if (kind == 1) begin
          send_word(exg_pkg::CMD_CONVERT, 1'b1, rand_chan(), rand_chan(), rand_chan());
        end else if (kind == 2) begin
          send_word(exg_pkg::CMD_CONVERT, 1'b0, CB'($urandom_range(0, 40)), rand_chan(),
                    CB'($urandom_range(0, 40)));
        end else begin
          send_word(exg_pkg::CMD_CONVERT, 1'b0, rand_chan(), rand_chan(), rand_chan());
        end
        sent++;
      end
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end
    steady = 1'b0;
  endtask

  // Result checker and random output stall.
  initial begin
    exg_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_exg.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("Result error: unexpected word exg=%0d sat=%0b", excess_green_o,
                     saturated_o);
        end else begin
          want = expected_exg.pop_front();
          if (excess_green_o !== want.value || saturated_o !== want.sat) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("Result error: expected exg=%0d sat=%0b, got exg=%0d sat=%0b",
                       want.value, want.sat, excess_green_o, saturated_o);
          end
        end
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < 32);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_peaks();
    test_directed_corners();
    test_drain_pause();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (expected_exg.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d measure and %0d convert words; %0d results checked.",
             measure_words, convert_words, results_seen);
    $display("Of the converted pixels %0d saturated and %0d came out as zero.",
             saturated_seen, zero_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/exg_pkg.sv
rtl/exg_peak.sv
rtl/exg_mul.sv
rtl/exg_div.sv
rtl/excess_green_pixel_index_core.sv
rtl/exg_check.sv
tb/tb_excess_green_pixel_index_core.sv
